>>> rtl/b2da_pkg.sv
`default_nettype none

package b2da_pkg;

    // Number of low decimal digits kept and printed
    localparam int DIGIT_COUNT = 5;

    // Field widths
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 6;
    localparam int BCD_W   = 4 * DIGIT_COUNT;

    // Bit counter for the conversion, counts 0 .. VALUE_W-1
    localparam int BIT_CNT_W = $clog2(VALUE_W);

    // Digit counter for emission, counts DIGIT_COUNT down to 1
    localparam int DIG_CNT_W = $clog2(DIGIT_COUNT + 1);

    // ASCII code of '0'
    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [BCD_W-1:0]   bcd_t;

endpackage

`default_nettype wire

>>> rtl/b2da_dabble.sv
`default_nettype none

module b2da_dabble
    import b2da_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire value_t in_value,
    output logic      bcd_valid,
    input  wire logic bcd_ready,
    output bcd_t      bcd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    value_t               bin_reg, bin_next;
    bcd_t                 bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;
    bcd_t                 bcd_adj;

    // Add three to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Sequence the load, the shift steps and the hand-off
    always_comb begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    bin_next   = in_value;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                // Shift one binary bit into the digit chain; the top carry drops out
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + BIT_CNT_W'(1);
                if (cnt_reg == BIT_CNT_W'(VALUE_W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (bcd_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign bcd_valid = (state_reg == ST_DONE);
    assign bcd       = bcd_reg;

endmodule

`default_nettype wire

>>> rtl/b2da_emit.sv
`default_nettype none

module b2da_emit
    import b2da_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        bcd_valid,
    output logic             bcd_ready,
    input  wire bcd_t        bcd,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [CHAR_W-1:0] out_char,
    output logic             out_last
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t               state_reg, state_next;
    bcd_t                 dig_reg, dig_next;
    logic [DIG_CNT_W-1:0] rem_reg, rem_next;
    logic                 started_reg, started_next;
    logic                 valid_reg, valid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;
    logic [3:0]           top_digit;
    logic                 slot_free;
    logic                 emit;

    assign top_digit = dig_reg[BCD_W-1 -: 4];
    assign slot_free = !valid_reg || out_ready;
    // Send once a nonzero digit was seen, and always the final digit
    assign emit      = started_reg || (top_digit != 4'd0) || (rem_reg == DIG_CNT_W'(1));

    // Walk the digits from the top, one per cycle while the output slot is free
    always_comb begin
        state_next   = state_reg;
        dig_next     = dig_reg;
        rem_next     = rem_reg;
        started_next = started_reg;
        valid_next   = valid_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (bcd_valid) begin
                    dig_next     = bcd;
                    rem_next     = DIG_CNT_W'(DIGIT_COUNT);
                    started_next = 1'b0;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN: begin
                if (slot_free) begin
                    if (emit) begin
                        valid_next   = 1'b1;
                        char_next    = ASCII_ZERO + CHAR_W'(top_digit);
                        last_next    = (rem_reg == DIG_CNT_W'(1));
                        started_next = 1'b1;
                    end
                    dig_next = dig_reg << 4;
                    rem_next = rem_reg - DIG_CNT_W'(1);
                    if (rem_reg == DIG_CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, digit shifter and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        dig_reg     <= dig_next;
        rem_reg     <= rem_next;
        started_reg <= started_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign bcd_ready = (state_reg == ST_IDLE);
    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

>>> rtl/binary_to_decimal_ascii_core.sv
`default_nettype none

// Prints an unsigned 32-bit value as its lowest five decimal digits in ASCII,
// most significant first, with leading zeros suppressed (zero gives one '0');
// higher digits are dropped, as for the value modulo 100000. The last character
// of each run has m_last_digit set. Each stage handles one item at a time: the
// shift-and-add-3 converter takes one input bit per cycle, then holds the
// digits in its done state until the emitter takes them; the emitter then
// walks one digit position per cycle while m_ready allows; stalls on m_ready slow it.
// The converter accepts the next item while the emitter still sends digits.
module binary_to_decimal_ascii_core
    import b2da_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [VALUE_W-1:0] s_value,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [CHAR_W-1:0]      m_ascii_char,
    output logic                   m_last_digit
);

    logic bcd_valid;
    logic bcd_ready;
    bcd_t bcd;

    // Convert binary to packed decimal, one bit per cycle
    b2da_dabble u_dabble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_value  (s_value),
        .bcd_valid (bcd_valid),
        .bcd_ready (bcd_ready),
        .bcd       (bcd)
    );

    // Send the digits, one per cycle while m_ready allows
    b2da_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .bcd_valid (bcd_valid),
        .bcd_ready (bcd_ready),
        .bcd       (bcd),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_char  (m_ascii_char),
        .out_last  (m_last_digit)
    );

endmodule

`default_nettype wire

>>> tb/binary_to_decimal_ascii_core_tb.sv
`timescale 1ns / 100ps

module binary_to_decimal_ascii_core_tb;
    import b2da_pkg::*;

    localparam int DECIMAL_BASE  = 10;
    localparam int RANDOM_ITEMS  = 320;
    localparam int DRAIN_CYCLES  = 80;
    localparam int CYCLE_LIMIT   = 400000;

    // One printed character as the block should send it
    typedef struct packed {
        logic [CHAR_W-1:0] ascii;
        logic              last;
    } digit_char_t;

    // Scoreboard: turns accepted values into expected characters and checks results
    class digit_scoreboard;
        digit_char_t pending_chars[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // Split the value into low decimal digits and queue them, top digit first
        function void note_value(value_t v);
            int unsigned rest;
            int unsigned dig[DIGIT_COUNT];
            int          top;
            digit_char_t item;
            rest = v;
            for (int pos = 0; pos < DIGIT_COUNT; pos++) begin
                dig[pos] = rest % DECIMAL_BASE;
                rest     = rest / DECIMAL_BASE;
            end
            // Suppress leading zeros but always keep the units digit
            top = DIGIT_COUNT - 1;
            while (top > 0 && dig[top] == 0) top--;
            for (int pos = top; pos >= 0; pos--) begin
                item.ascii = ASCII_ZERO + CHAR_W'(dig[pos]);
                item.last  = (pos == 0);
                pending_chars.push_back(item);
            end
        endfunction

        // Compare one accepted character against the oldest expectation
        function void check_char(logic [CHAR_W-1:0] ascii, logic last);
            digit_char_t exp_char;
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character: ascii %0d last %0b",
                         $time, ascii, last);
                errors++;
                return;
            end
            exp_char = pending_chars.pop_front();
            if (ascii !== exp_char.ascii) begin
                $display("%0t: ascii_char mismatch: expected %0d actual %0d",
                         $time, exp_char.ascii, ascii);
                errors++;
            end
            if (last !== exp_char.last) begin
                $display("%0t: last_digit mismatch: expected %0b actual %0b",
                         $time, exp_char.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [VALUE_W-1:0]  s_value;
    logic                m_valid;
    logic                m_ready;
    logic [CHAR_W-1:0]   m_ascii_char;
    logic                m_last_digit;

    digit_scoreboard sb = new();
    int              cycle_count = 0;
    int              values_sent = 0;
    int              chars_seen  = 0;
    int              burst_left  = 0;

    binary_to_decimal_ascii_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ascii_char (m_ascii_char),
        .m_last_digit (m_last_digit)
    );

    // 4 ns clock
    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d characters outstanding", $time, sb.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Check every character accepted on the result side
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_char(m_ascii_char, m_last_digit);
            chars_seen++;
        end
    end

    // Drive m_ready from a changing stall pattern
    initial begin
        int mode;
        int mode_left;
        int hold;
        logic next_ready;
        m_ready   = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold      = 0;
        forever begin
            @(negedge aclk);
            if (mode_left == 0) begin
                mode      = $urandom_range(3);
                mode_left = $urandom_range(150, 50);
            end
            mode_left--;
            if (hold > 0) begin
                hold--;
            end else begin
                case (mode)
                    0: next_ready = 1'b1;
                    1: next_ready = 1'($urandom_range(1));
                    2: next_ready = ($urandom_range(3) == 0);
                    default: begin
                        next_ready = !m_ready;
                        hold = next_ready ? $urandom_range(4) : $urandom_range(29);
                    end
                endcase
                m_ready <= next_ready;
            end
        end
    end

    // Offer one value, with bursts separated by random idle gaps
    task automatic send_value(input value_t v);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap        = $urandom_range(12);
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 20)
                                                  : $urandom_range(16, 1);
        end
        burst_left--;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_value <= v;
        // Hold the item until it is taken
        do @(posedge aclk); while (!s_ready);
        sb.note_value(v);
        values_sent++;
    endtask

    // Pick a value from one of several classes that stress digit suppression
    function automatic value_t random_value();
        value_t      v;
        int unsigned pow10;
        pow10 = 1;
        repeat ($urandom_range(DIGIT_COUNT)) pow10 = pow10 * DECIMAL_BASE;
        case ($urandom_range(9))
            0, 1, 2: v = $urandom;
            3, 4:    v = $urandom_range(99999);
            5:       v = $urandom_range(999);
            6:       v = $urandom_range(9) * pow10;
            7:       v = $urandom_range(42948) * 100000 + $urandom_range(20);
            8:       v = value_t'(1) << $urandom_range(VALUE_W - 1);
            default: v = ~(value_t'(0)) >> $urandom_range(VALUE_W - 1);
        endcase
        return v;
    endfunction

    // Stimulus and end of run
    initial begin
        value_t directed[$];
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_value = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Extremes, zero, and values at and above the five-digit range
        directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd1000,
                     32'd9999, 32'd10000, 32'd10001, 32'd12345, 32'd54321,
                     32'd90000, 32'd99990, 32'd99999, 32'd100000, 32'd100001,
                     32'd123456, 32'd200000, 32'h0000FFFF, 32'h80000000,
                     32'hFFFFFFFF, 32'd5};
        foreach (directed[i]) send_value(directed[i]);

        repeat (RANDOM_ITEMS) send_value(random_value());

        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain outstanding characters, then watch for strays
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d values (%0d directed) and checked %0d characters",
                 values_sent, directed.size(), chars_seen);
        $display("with bursty input and a varying output stall pattern.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
